// File: rtl/ccei_pkg.sv
// shared types and constants of the cuckoo cycle edge inserter
package ccei_pkg;

	localparam int EDGE_W = 16;
	localparam int NODE_W = 16;
	localparam int LEN_W  = 14;
	localparam logic [LEN_W-1:0] PROOF_RESET = 14'd42;

	typedef enum logic [2:0] {
		OUT_LINKED   = 3'd0,
		OUT_CYCLE    = 3'd1,
		OUT_PROOF    = 3'd2,
		OUT_NIL      = 3'd3,
		OUT_OVERFLOW = 3'd4,
		OUT_ILLEGAL  = 3'd5
	} outcome_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CAPTURE,
		OP_WALK1_START,
		OP_WALK2_START,
		OP_WALK_STEP,
		OP_WALK_END,
		OP_SRCH_START,
		OP_SRCH_STEP,
		OP_CYC_START,
		OP_CYC_STEP,
		OP_REV_START,
		OP_REV_READ,
		OP_REV_WRITE,
		OP_LINK
	} dp_op_t;

	typedef struct packed {
		dp_op_t   op;
		logic     res_load;
		outcome_t res_code;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic first_nil;
		logic walk_nil;
		logic walk_full;
		logic srch_hit;
		logic srch_zero;
		logic roots_eq;
		logic first_shorter;
		logic cyc_eq;
		logic cyc_proof;
		logic n_zero;
		logic out_full;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_WALK1,
		ST_W2_START,
		ST_WALK2,
		ST_SRCH,
		ST_DECIDE,
		ST_CYC,
		ST_REV,
		ST_REV_W,
		ST_LINK,
		ST_RES
	} state_t;

endpackage

// File: rtl/ccei_ram.sv
// generic simple dual port ram with registered read
module ccei_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ccei_datapath.sv
// datapath: node table, path buffers, counters and result register
module ccei_datapath #(
	parameter int NODE_BITS = 16,
	parameter int MAX_PATH  = 8192
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ccei_pkg::dp_cmd_t           cmd,
	output ccei_pkg::dp_stat_t          stat,
	input  logic                        cfg_we,
	input  logic [ccei_pkg::LEN_W-1:0]  cfg_wdata,
	input  logic [ccei_pkg::EDGE_W-1:0] edge_id,
	input  logic [ccei_pkg::NODE_W-1:0] node_first,
	input  logic [ccei_pkg::NODE_W-1:0] node_second,
	input  logic                        result_stall,
	output logic                        result_valid,
	output logic [ccei_pkg::EDGE_W-1:0] edge_tag,
	output logic [2:0]                  outcome,
	output logic [ccei_pkg::LEN_W-1:0]  cycle_length
);

	localparam int NB = NODE_BITS;
	localparam int AW = $clog2(MAX_PATH);
	localparam int CW = $clog2(MAX_PATH + 1);
	localparam int SW = (CW + 1 > ccei_pkg::LEN_W) ? CW + 1 : ccei_pkg::LEN_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_PATH - 1);
	localparam logic [CW-1:0] FULL_N = CW'(MAX_PATH - 1);

	logic [NB-1:0] clr_addr_q;
	logic [ccei_pkg::LEN_W-1:0] proof_q;
	logic out_valid_q;

	logic [ccei_pkg::EDGE_W-1:0] edge_q;
	logic [NB-1:0] u0_q, v0_q, cur_q, root1_q, root2_q, target_q, hi_q;
	logic [CW-1:0] n_q, n1_q, n2_q, k_q, i1_q, i2_q;
	logic sel_q;
	ccei_pkg::outcome_t res_code_q;
	logic [ccei_pkg::EDGE_W-1:0] res_tag_q;
	logic [ccei_pkg::LEN_W-1:0] res_len_q;

	logic nt_we, nt_re;
	logic [NB-1:0] nt_waddr, nt_raddr, nt_wdata, nt_rdata;
	logic pf_we, ps_we, pf_re, ps_re;
	logic [AW-1:0] p_waddr, pf_raddr, ps_raddr;
	logic [NB-1:0] pf_wdata, ps_wdata, pf_rdata, ps_rdata, path_rd;

	logic [CW-1:0] n_inc, n_dec, k_dec, diff, i1_start, i2_start;
	logic first_shorter;
	logic [SW-1:0] cyc_sum, bad_sum;
	logic [ccei_pkg::LEN_W-1:0] cyc_len, bad_len, res_len_d;
	logic out_full;

	ccei_ram #(.WIDTH(NB), .DEPTH(2 ** NB)) u_node_ram (
		.clk(clk), .we(nt_we), .waddr(nt_waddr), .wdata(nt_wdata),
		.re(nt_re), .raddr(nt_raddr), .rdata(nt_rdata)
	);

	ccei_ram #(.WIDTH(NB), .DEPTH(MAX_PATH)) u_path_first (
		.clk(clk), .we(pf_we), .waddr(p_waddr), .wdata(pf_wdata),
		.re(pf_re), .raddr(pf_raddr), .rdata(pf_rdata)
	);

	ccei_ram #(.WIDTH(NB), .DEPTH(MAX_PATH)) u_path_second (
		.clk(clk), .we(ps_we), .waddr(p_waddr), .wdata(ps_wdata),
		.re(ps_re), .raddr(ps_raddr), .rdata(ps_rdata)
	);

	assign path_rd       = sel_q ? ps_rdata : pf_rdata;
	assign n_inc         = n_q + CW'(1);
	assign n_dec         = n_q - CW'(1);
	assign k_dec         = k_q - CW'(1);
	assign first_shorter = n1_q < n2_q;
	assign diff          = first_shorter ? (n2_q - n1_q) : (n1_q - n2_q);
	assign i1_start      = first_shorter ? '0 : diff;
	assign i2_start      = first_shorter ? diff : '0;
	assign cyc_sum       = SW'(i1_q) + SW'(i2_q) + SW'(1);
	assign cyc_len       = cyc_sum[ccei_pkg::LEN_W-1:0];
	assign bad_sum       = SW'(MAX_PATH) - SW'(k_q);
	assign bad_len       = bad_sum[ccei_pkg::LEN_W-1:0];
	assign out_full      = out_valid_q && result_stall;

	always_comb begin
		nt_we    = 1'b0;
		nt_waddr = hi_q;
		nt_wdata = path_rd;
		nt_re    = 1'b0;
		nt_raddr = nt_rdata;
		pf_we    = 1'b0;
		ps_we    = 1'b0;
		p_waddr  = '0;
		pf_wdata = u0_q;
		ps_wdata = v0_q;
		pf_re    = 1'b0;
		ps_re    = 1'b0;
		pf_raddr = n_dec[AW-1:0];
		ps_raddr = n_dec[AW-1:0];
		unique case (cmd.op)
			ccei_pkg::OP_CLEAR: begin
				nt_we    = 1'b1;
				nt_waddr = clr_addr_q;
				nt_wdata = '0;
			end
			ccei_pkg::OP_WALK1_START: begin
				nt_re    = 1'b1;
				nt_raddr = u0_q;
				pf_we    = 1'b1;
				ps_we    = 1'b1;
			end
			ccei_pkg::OP_WALK2_START: begin
				nt_re    = 1'b1;
				nt_raddr = v0_q;
			end
			ccei_pkg::OP_WALK_STEP: begin
				nt_re    = 1'b1;
				p_waddr  = n_inc[AW-1:0];
				pf_we    = !sel_q;
				ps_we    = sel_q;
				pf_wdata = nt_rdata;
				ps_wdata = nt_rdata;
			end
			ccei_pkg::OP_SRCH_START: begin
				pf_re    = !sel_q;
				ps_re    = sel_q;
				pf_raddr = LAST_IDX;
				ps_raddr = LAST_IDX;
			end
			ccei_pkg::OP_SRCH_STEP: begin
				pf_re    = !sel_q;
				ps_re    = sel_q;
				pf_raddr = k_dec[AW-1:0];
				ps_raddr = k_dec[AW-1:0];
			end
			ccei_pkg::OP_CYC_START: begin
				pf_re    = 1'b1;
				ps_re    = 1'b1;
				pf_raddr = i1_start[AW-1:0];
				ps_raddr = i2_start[AW-1:0];
			end
			ccei_pkg::OP_CYC_STEP: begin
				pf_re    = 1'b1;
				ps_re    = 1'b1;
				pf_raddr = AW'(i1_q + CW'(1));
				ps_raddr = AW'(i2_q + CW'(1));
			end
			ccei_pkg::OP_REV_READ: begin
				pf_re = !sel_q;
				ps_re = sel_q;
			end
			ccei_pkg::OP_REV_WRITE: begin
				nt_we = 1'b1;
				pf_re = !sel_q && (n_q != '0);
				ps_re = sel_q && (n_q != '0);
			end
			ccei_pkg::OP_LINK: begin
				nt_we    = 1'b1;
				nt_waddr = sel_q ? v0_q : u0_q;
				nt_wdata = sel_q ? u0_q : v0_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (cmd.res_code)
			ccei_pkg::OUT_CYCLE, ccei_pkg::OUT_PROOF: res_len_d = cyc_len;
			ccei_pkg::OUT_ILLEGAL:                    res_len_d = bad_len;
			default:                                  res_len_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			proof_q     <= ccei_pkg::PROOF_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == ccei_pkg::OP_CLEAR) begin
				clr_addr_q <= clr_addr_q + NB'(1);
			end
			if (cfg_we) begin
				proof_q <= cfg_wdata;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ccei_pkg::OP_CAPTURE: begin
				edge_q <= edge_id;
				u0_q   <= NB'(node_first);
				v0_q   <= NB'(node_second);
			end
			ccei_pkg::OP_WALK1_START: begin
				sel_q <= 1'b0;
				n_q   <= '0;
				cur_q <= u0_q;
			end
			ccei_pkg::OP_WALK2_START: begin
				sel_q <= 1'b1;
				n_q   <= '0;
				cur_q <= v0_q;
			end
			ccei_pkg::OP_WALK_STEP: begin
				n_q   <= n_inc;
				cur_q <= nt_rdata;
			end
			ccei_pkg::OP_WALK_END: begin
				if (sel_q) begin
					n2_q    <= n_q;
					root2_q <= cur_q;
				end else begin
					n1_q    <= n_q;
					root1_q <= cur_q;
				end
			end
			ccei_pkg::OP_SRCH_START: begin
				k_q      <= FULL_N;
				target_q <= nt_rdata;
			end
			ccei_pkg::OP_SRCH_STEP: begin
				k_q <= k_dec;
			end
			ccei_pkg::OP_CYC_START: begin
				i1_q <= i1_start;
				i2_q <= i2_start;
			end
			ccei_pkg::OP_CYC_STEP: begin
				i1_q <= i1_q + CW'(1);
				i2_q <= i2_q + CW'(1);
			end
			ccei_pkg::OP_REV_START: begin
				// reverse the shorter path, the second one on a tie
				sel_q <= !first_shorter;
				n_q   <= first_shorter ? n1_q : n2_q;
				hi_q  <= first_shorter ? root1_q : root2_q;
			end
			ccei_pkg::OP_REV_READ: begin
				n_q <= n_dec;
			end
			ccei_pkg::OP_REV_WRITE: begin
				hi_q <= path_rd;
				if (n_q != '0) begin
					n_q <= n_dec;
				end
			end
			default: begin
			end
		endcase
		if (cmd.res_load) begin
			res_code_q <= cmd.res_code;
			res_tag_q  <= edge_q;
			res_len_q  <= res_len_d;
		end
	end

	always_comb begin
		stat.clr_last      = &clr_addr_q;
		stat.first_nil     = u0_q == '0;
		stat.walk_nil      = nt_rdata == '0;
		stat.walk_full     = n_q == FULL_N;
		stat.srch_hit      = path_rd == target_q;
		stat.srch_zero     = k_q == '0;
		stat.roots_eq      = root1_q == root2_q;
		stat.first_shorter = first_shorter;
		stat.cyc_eq        = pf_rdata == ps_rdata;
		stat.cyc_proof     = cyc_len == proof_q;
		stat.n_zero        = n_q == '0;
		stat.out_full      = out_full;
	end

	assign result_valid = out_valid_q;
	assign edge_tag     = res_tag_q;
	assign outcome      = res_code_q;
	assign cycle_length = res_len_q;

endmodule

// File: rtl/ccei_ctrl.sv
// controller state machine sequencing the walks, search, cycle scan and reversal
module ccei_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               edge_valid,
	output logic               edge_stall,
	input  ccei_pkg::dp_stat_t stat,
	output ccei_pkg::dp_cmd_t  cmd
);

	ccei_pkg::state_t   state_q, state_d;
	ccei_pkg::outcome_t code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccei_pkg::ST_CLEAR;
			code_q  <= ccei_pkg::OUT_LINKED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		unique case (state_q)
			ccei_pkg::ST_CLEAR: begin
				if (stat.clr_last) state_d = ccei_pkg::ST_IDLE;
			end
			ccei_pkg::ST_IDLE: begin
				if (edge_valid) state_d = ccei_pkg::ST_DISPATCH;
			end
			ccei_pkg::ST_DISPATCH: begin
				if (stat.first_nil) begin
					code_d  = ccei_pkg::OUT_NIL;
					state_d = ccei_pkg::ST_RES;
				end else begin
					state_d = ccei_pkg::ST_WALK1;
				end
			end
			ccei_pkg::ST_WALK1, ccei_pkg::ST_WALK2: begin
				priority if (stat.walk_nil) begin
					state_d = (state_q == ccei_pkg::ST_WALK1) ? ccei_pkg::ST_W2_START
						: ccei_pkg::ST_DECIDE;
				end else if (stat.walk_full) begin
					state_d = ccei_pkg::ST_SRCH;
				end else begin
					state_d = state_q;
				end
			end
			ccei_pkg::ST_W2_START: state_d = ccei_pkg::ST_WALK2;
			ccei_pkg::ST_SRCH: begin
				priority if (stat.srch_hit) begin
					code_d  = ccei_pkg::OUT_ILLEGAL;
					state_d = ccei_pkg::ST_RES;
				end else if (stat.srch_zero) begin
					code_d  = ccei_pkg::OUT_OVERFLOW;
					state_d = ccei_pkg::ST_RES;
				end else begin
					state_d = state_q;
				end
			end
			ccei_pkg::ST_DECIDE: begin
				state_d = stat.roots_eq ? ccei_pkg::ST_CYC : ccei_pkg::ST_REV;
			end
			ccei_pkg::ST_CYC: begin
				if (stat.cyc_eq) begin
					code_d  = stat.cyc_proof ? ccei_pkg::OUT_PROOF : ccei_pkg::OUT_CYCLE;
					state_d = ccei_pkg::ST_RES;
				end
			end
			ccei_pkg::ST_REV: begin
				state_d = stat.n_zero ? ccei_pkg::ST_LINK : ccei_pkg::ST_REV_W;
			end
			ccei_pkg::ST_REV_W: begin
				if (stat.n_zero) state_d = ccei_pkg::ST_LINK;
			end
			ccei_pkg::ST_LINK: begin
				code_d  = ccei_pkg::OUT_LINKED;
				state_d = ccei_pkg::ST_RES;
			end
			ccei_pkg::ST_RES: begin
				if (!stat.out_full) state_d = ccei_pkg::ST_IDLE;
			end
			default: state_d = ccei_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op       = ccei_pkg::OP_NONE;
		cmd.res_load = 1'b0;
		cmd.res_code = code_q;
		edge_stall   = state_q != ccei_pkg::ST_IDLE;
		unique case (state_q)
			ccei_pkg::ST_CLEAR: cmd.op = ccei_pkg::OP_CLEAR;
			ccei_pkg::ST_IDLE: begin
				if (edge_valid) cmd.op = ccei_pkg::OP_CAPTURE;
			end
			ccei_pkg::ST_DISPATCH: begin
				if (!stat.first_nil) cmd.op = ccei_pkg::OP_WALK1_START;
			end
			ccei_pkg::ST_WALK1, ccei_pkg::ST_WALK2: begin
				priority if (stat.walk_nil) cmd.op = ccei_pkg::OP_WALK_END;
				else if (stat.walk_full)   cmd.op = ccei_pkg::OP_SRCH_START;
				else                       cmd.op = ccei_pkg::OP_WALK_STEP;
			end
			ccei_pkg::ST_W2_START: cmd.op = ccei_pkg::OP_WALK2_START;
			ccei_pkg::ST_SRCH: begin
				if (!stat.srch_hit && !stat.srch_zero) cmd.op = ccei_pkg::OP_SRCH_STEP;
			end
			ccei_pkg::ST_DECIDE: begin
				cmd.op = stat.roots_eq ? ccei_pkg::OP_CYC_START : ccei_pkg::OP_REV_START;
			end
			ccei_pkg::ST_CYC: begin
				if (!stat.cyc_eq) cmd.op = ccei_pkg::OP_CYC_STEP;
			end
			ccei_pkg::ST_REV: begin
				if (!stat.n_zero) cmd.op = ccei_pkg::OP_REV_READ;
			end
			ccei_pkg::ST_REV_W: cmd.op = ccei_pkg::OP_REV_WRITE;
			ccei_pkg::ST_LINK:  cmd.op = ccei_pkg::OP_LINK;
			ccei_pkg::ST_RES:   cmd.res_load = !stat.out_full;
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/cuckoo_cycle_edge_inserter_core.sv
// top level of the cuckoo cycle edge inserter
//
// channel   direction  handshake                 payload
// edge      in         edge_valid / edge_stall   edge_id, node_first, node_second
// result    out        result_valid / result_stall  edge_tag, outcome, cycle_length
// config    in         cfg_we                    cfg_wdata (proof length)
//
// one transaction at a time; both root paths are walked, one node table read per step,
// and for a linked edge the shorter path is then reversed
// a path that reaches the buffer depth adds a loop search over the buffer entries
// after reset the node table is cleared, one entry a cycle, over all 2**NODE_BITS entries
// the next edge is taken while a result waits; a result stalled downstream holds the block before its next result
module cuckoo_cycle_edge_inserter_core #(
	parameter int NODE_BITS = 16,
	parameter int MAX_PATH  = 8192
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ccei_pkg::LEN_W-1:0]  cfg_wdata,
	input  logic                        edge_valid,
	output logic                        edge_stall,
	input  logic [ccei_pkg::EDGE_W-1:0] edge_id,
	input  logic [ccei_pkg::NODE_W-1:0] node_first,
	input  logic [ccei_pkg::NODE_W-1:0] node_second,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [ccei_pkg::EDGE_W-1:0] edge_tag,
	output logic [2:0]                  outcome,
	output logic [ccei_pkg::LEN_W-1:0]  cycle_length
);

	ccei_pkg::dp_cmd_t  cmd;
	ccei_pkg::dp_stat_t stat;

	ccei_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .edge_valid(edge_valid), .edge_stall(edge_stall),
		.stat(stat), .cmd(cmd)
	);

	ccei_datapath #(.NODE_BITS(NODE_BITS), .MAX_PATH(MAX_PATH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.edge_id(edge_id), .node_first(node_first), .node_second(node_second),
		.result_stall(result_stall), .result_valid(result_valid),
		.edge_tag(edge_tag), .outcome(outcome), .cycle_length(cycle_length)
	);

endmodule

// File: rtl/ccei_checker.sv
// port level checker for the edge inserter, bound to the top level
module ccei_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_we,
	input logic [ccei_pkg::LEN_W-1:0]  cfg_wdata,
	input logic                        edge_valid,
	input logic                        edge_stall,
	input logic [ccei_pkg::EDGE_W-1:0] edge_id,
	input logic [ccei_pkg::NODE_W-1:0] node_first,
	input logic [ccei_pkg::NODE_W-1:0] node_second,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [ccei_pkg::EDGE_W-1:0] edge_tag,
	input logic [2:0]                  outcome,
	input logic [ccei_pkg::LEN_W-1:0]  cycle_length
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(edge_tag)
			&& $stable(outcome) && $stable(cycle_length))
		else $error("stalled result changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> outcome <= ccei_pkg::OUT_ILLEGAL)
		else $error("unknown outcome code");

	// no cycle means no length
	a_nolen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (outcome == ccei_pkg::OUT_LINKED || outcome == ccei_pkg::OUT_NIL
			|| outcome == ccei_pkg::OUT_OVERFLOW) |-> cycle_length == '0)
		else $error("length reported without a cycle");

	// the input stalls in the cycle after each accepted transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		edge_valid && !edge_stall |=> edge_stall)
		else $error("edge taken while a transaction is in work");

endmodule

bind cuckoo_cycle_edge_inserter_core ccei_checker u_ccei_checker (.*);

// File: tb/testbench.sv
// self-checking testbench for the cuckoo cycle edge inserter core
`timescale 1ns / 100ps

module testbench;

	localparam int NODES = 1 << ccei_pkg::NODE_W;
	localparam int PATH_MAX = 8192;

	typedef struct packed {
		logic [ccei_pkg::EDGE_W-1:0] id;
		logic [ccei_pkg::NODE_W-1:0] u;
		logic [ccei_pkg::NODE_W-1:0] v;
	} edge_item_t;

	typedef struct packed {
		logic [ccei_pkg::EDGE_W-1:0] tag;
		ccei_pkg::outcome_t          code;
		logic [ccei_pkg::LEN_W-1:0]  len;
	} edge_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ccei_pkg::LEN_W-1:0] cfg_wdata = '0;
	logic edge_valid = 1'b0;
	logic edge_stall;
	logic [ccei_pkg::EDGE_W-1:0] edge_id = '0;
	logic [ccei_pkg::NODE_W-1:0] node_first = '0;
	logic [ccei_pkg::NODE_W-1:0] node_second = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [ccei_pkg::EDGE_W-1:0] edge_tag;
	logic [2:0] outcome;
	logic [ccei_pkg::LEN_W-1:0] cycle_length;

	cuckoo_cycle_edge_inserter_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.edge_valid(edge_valid), .edge_stall(edge_stall), .edge_id(edge_id),
		.node_first(node_first), .node_second(node_second),
		.result_valid(result_valid), .result_stall(result_stall),
		.edge_tag(edge_tag), .outcome(outcome), .cycle_length(cycle_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// forest model and current proof length
	logic [ccei_pkg::NODE_W-1:0] forest [NODES];
	logic [ccei_pkg::NODE_W-1:0] walk_a [PATH_MAX];
	logic [ccei_pkg::NODE_W-1:0] walk_b [PATH_MAX];
	logic [ccei_pkg::LEN_W-1:0] proof_len = ccei_pkg::PROOF_RESET;

	edge_item_t pending_edges[$];
	edge_result_t expected_results[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int proofs = 0;
	int cycles_seen = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_off = 1'b0;

	function automatic ccei_pkg::outcome_t root_walk(input logic [ccei_pkg::NODE_W-1:0] start,
			input bit second, output int steps, output int bad);
		int n;
		logic [ccei_pkg::NODE_W-1:0] x;
		n = 0;
		x = start;
		bad = 0;
		steps = 0;
		while (x != 0) begin
			n++;
			if (n >= PATH_MAX) begin
				for (int k = n - 1; k >= 0; k--) begin
					if ((second ? walk_b[k] : walk_a[k]) == x) begin
						bad = PATH_MAX - k;
						return ccei_pkg::OUT_ILLEGAL;
					end
				end
				return ccei_pkg::OUT_OVERFLOW;
			end
			if (second) walk_b[n] = x;
			else walk_a[n] = x;
			x = forest[x];
		end
		steps = n;
		return ccei_pkg::OUT_LINKED;
	endfunction

	function automatic edge_result_t insert_edge(input edge_item_t it);
		edge_result_t r;
		int na, nb, bad, m;
		r.tag = it.id;
		r.code = ccei_pkg::OUT_LINKED;
		r.len = '0;
		na = 0;
		nb = 0;
		if (it.u == 0) begin
			r.code = ccei_pkg::OUT_NIL;
			return r;
		end
		walk_a[0] = it.u;
		walk_b[0] = it.v;
		r.code = root_walk(forest[it.u], 1'b0, na, bad);
		if (r.code == ccei_pkg::OUT_LINKED) r.code = root_walk(forest[it.v], 1'b1, nb, bad);
		if (r.code == ccei_pkg::OUT_ILLEGAL) begin
			r.len = ccei_pkg::LEN_W'(bad);
		end else if (r.code == ccei_pkg::OUT_LINKED) begin
			if (walk_a[na] == walk_b[nb]) begin
				m = na < nb ? na : nb;
				na -= m;
				nb -= m;
				while (walk_a[na] != walk_b[nb]) begin
					na++;
					nb++;
				end
				r.len = ccei_pkg::LEN_W'(na + nb + 1);
				r.code = (r.len == proof_len) ? ccei_pkg::OUT_PROOF : ccei_pkg::OUT_CYCLE;
			end else if (na < nb) begin
				while (na > 0) begin
					na--;
					forest[walk_a[na + 1]] = walk_a[na];
				end
				forest[it.u] = it.v;
			end else begin
				while (nb > 0) begin
					nb--;
					forest[walk_b[nb + 1]] = walk_b[nb];
				end
				forest[it.v] = it.u;
			end
		end
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_valid <= 1'b0;
		end else if (!edge_valid || !edge_stall) begin
			if (edge_valid) begin
				expected_results.push_back(insert_edge({edge_id, node_first, node_second}));
				sent++;
			end
			if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				edge_item_t it;
				it = pending_edges.pop_front();
				edge_valid <= 1'b1;
				edge_id <= it.id;
				node_first <= it.u;
				node_second <= it.v;
			end else begin
				edge_valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				edge_result_t e;
				received++;
				if (expected_results.size() == 0) begin
					$error("result with no transaction pending: tag %0d", edge_tag);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (edge_tag !== e.tag) begin
						$error("edge_tag expected %0d actual %0d", e.tag, edge_tag);
						errors++;
					end
					if (outcome !== e.code) begin
						$error("outcome expected %0d actual %0d", e.code, outcome);
						errors++;
					end
					if (cycle_length !== e.len) begin
						$error("cycle_length expected %0d actual %0d", e.len, cycle_length);
						errors++;
					end
					if (e.code == ccei_pkg::OUT_PROOF) proofs++;
					if (e.code == ccei_pkg::OUT_CYCLE) cycles_seen++;
				end
			end
			result_stall <= hold_off || ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [ccei_pkg::NODE_W-1:0] even_node(input int span);
		return ccei_pkg::NODE_W'(2 * $urandom_range(span, 1));
	endfunction

	function automatic logic [ccei_pkg::NODE_W-1:0] odd_node(input int span);
		return ccei_pkg::NODE_W'(2 * $urandom_range(span, 0) + 1);
	endfunction

	task automatic queue_edge(input logic [ccei_pkg::NODE_W-1:0] u,
			input logic [ccei_pkg::NODE_W-1:0] v);
		pending_edges.push_back({ccei_pkg::EDGE_W'($urandom), u, v});
	endtask

	task automatic drain();
		while (pending_edges.size() > 0 || edge_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_proof_len(input logic [ccei_pkg::LEN_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		proof_len = val;
	endtask

	// closed ring of a given length over fresh nodes starting at base
	task automatic queue_ring(input int base, input int len);
		for (int k = 0; k < len / 2; k++) begin
			queue_edge(ccei_pkg::NODE_W'(base + 2 * k), ccei_pkg::NODE_W'(base + 2 * k + 1));
			queue_edge(ccei_pkg::NODE_W'(base + 2 * ((k + 1) % (len / 2))),
				ccei_pkg::NODE_W'(base + 2 * k + 1));
		end
	endtask

	initial begin
		for (int i = 0; i < NODES; i++) forest[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: nil, extremes, cycles, proof at reset length
		pending_edges.push_back({16'hFFFF, 16'h0000, 16'h0001});
		pending_edges.push_back({16'h0000, 16'h0000, 16'hFFFF});
		pending_edges.push_back({16'hA5A5, 16'hFFFE, 16'hFFFF});
		pending_edges.push_back({16'h5A5A, 16'hFFFE, 16'h0000});
		pending_edges.push_back({16'h1234, 16'h0002, 16'h0000});
		pending_edges.push_back({16'h0001, 16'hFFFF, 16'hFFFE});
		queue_ring(16'h0100, 4);
		queue_ring(16'h0200, 6);
		queue_ring(16'h0400, 42);
		drain();

		write_proof_len(14'd2);
		queue_edge(16'h0800, 16'h0801);
		queue_edge(16'h0800, 16'h0801);
		drain();
		write_proof_len(14'h3FFF);
		queue_ring(16'h0900, 8);
		drain();
		write_proof_len(14'd8192);

		// random phases, small node ranges so trees and cycles form
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 85; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 85; end
				default: begin send_idle_pct = 19; stall_pct = 19; end
			endcase
			write_proof_len(ccei_pkg::LEN_W'(2 * $urandom_range(6, 1)));
			for (int i = 0; i < 250; i++) begin
				case ($urandom_range(9))
					0: pending_edges.push_back({ccei_pkg::EDGE_W'($urandom),
						ccei_pkg::NODE_W'($urandom), ccei_pkg::NODE_W'($urandom)});
					1: queue_edge('0, ccei_pkg::NODE_W'($urandom));
					2, 3: queue_edge(even_node(32000), odd_node(32000));
					default: queue_edge(even_node(40), odd_node(40));
				endcase
			end
			if (ph == 0) begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			drain();
		end
		send_idle_pct = 0;
		stall_pct = 0;

		$display("edges sent %0d, results checked %0d, cycles %0d, proofs %0d",
			sent, received, cycles_seen, proofs);
		$display("covered nil edges, full-width nodes, rings and proof lengths 2 to 8192");
		if (errors == 0)
			$display("PASS cuckoo_cycle_edge_inserter_core");
		else
			$display("FAIL cuckoo_cycle_edge_inserter_core");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL cuckoo_cycle_edge_inserter_core");
		$finish;
	end

endmodule

// File: files.f
rtl/ccei_pkg.sv
rtl/ccei_ram.sv
rtl/ccei_datapath.sv
rtl/ccei_ctrl.sv
rtl/cuckoo_cycle_edge_inserter_core.sv
rtl/ccei_checker.sv
tb/testbench.sv
